// ===== hw/rtl/mrfdo_pkg.sv =====
// Shared types, constants and helper functions of the message ring store.
package mrfdo_pkg;

	localparam int DEPTH_WORDS   = 1024;
	localparam int MAX_MSG_WORDS = 32;
	localparam int IDX_W         = $clog2(DEPTH_WORDS);
	localparam int SZ_W          = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;
	localparam int SUM_W         = SZ_W + 1;
	localparam int LW_W          = 7;
	localparam int HDR_MIN       = 4;
	localparam int MAX_BYTES     = 4 * MAX_MSG_WORDS;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [SZ_W-1:0]  sz_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [LW_W-1:0]  lw_t;
	typedef logic [8:0]       blen_t;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_READ  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BIG    = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DROP,
		S_DROP_CHK,
		S_WR_FIN,
		S_COMMIT_ZERO,
		S_COMMIT_HDR,
		S_WR_EMIT,
		S_RD_HDR,
		S_RD_REQ,
		S_RD_WORD
	} state_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] data_word;
		logic [7:0]  byte_length;
		logic        last;
		logic [7:0]  max_bytes;
	} req_word_t;

	typedef struct packed {
		logic [31:0] word_out;
		logic        last_out;
		status_t     status;
		logic [15:0] message_count;
		logic [31:0] lost_count;
	} rsp_word_t;

	typedef struct packed {
		logic      valid;
		rsp_word_t word;
	} emit_t;

	typedef struct packed {
		logic        we;
		idx_t        waddr;
		logic [31:0] wdata;
		logic        re;
		idx_t        raddr;
	} ram_req_t;

	// words taken by a record of the given byte length, header included
	function automatic lw_t words_of(input logic [7:0] b);
		return lw_t'({1'b0, b[7:2]}) + lw_t'(|b[1:0]);
	endfunction

	// word count of a stored header, clamped to the largest record
	function automatic lw_t record_words(input logic [31:0] h);
		logic [30:0] n;
		n = {1'b0, h[31:2]} + 31'(|h[1:0]);
		if (n > 31'(MAX_MSG_WORDS))
			return lw_t'(MAX_MSG_WORDS);
		return n[LW_W-1:0];
	endfunction

	function automatic idx_t wrap_add(input idx_t a, input sz_t b);
		sum_t s;
		s = sum_t'(a) + sum_t'(b);
		if (s >= sum_t'(DEPTH_WORDS))
			s = s - sum_t'(DEPTH_WORDS);
		return s[IDX_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/message_ring_fifo_drop_oldest.sv =====
// Top level of the drop-oldest message ring store.
//
// Request channel (req_valid / req_stall / req_word): each word either writes
// one message word or asks for the oldest stored message. The first word of
// a message carries its byte length; the block drops the oldest messages until
// the record plus an end marker fits, or rejects the message.
// Response channel (rsp_valid / rsp_stall / rsp_word): one result per write
// word; a read gives the whole record, header first, or one status word.
// After reset the 1024-word store is swept to zero, one word per cycle, and
// requests are stalled during that sweep. Timing: one request at a time. A
// plain message word is stored, then its result is handed over. The first
// word of a message checks for room, reading and dropping one oldest record
// per failed check; a length out of range skips that. The closing word also
// writes the end marker, then the header. A read fetches each word of the
// record from the store, whose read data is registered, then hands it out.
// A stalled receiver holds the result in the output register; the block keeps
// working on the current request until it needs to hand over the next word.
module message_ring_fifo_drop_oldest (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  mrfdo_pkg::req_word_t req_word,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output mrfdo_pkg::rsp_word_t rsp_word
);

	mrfdo_pkg::emit_t    emit;
	logic                emit_ready;
	mrfdo_pkg::ram_req_t ram_req;
	logic [31:0]         ram_rdata;

	mrfdo_ram #(
		.WIDTH(32),
		.DEPTH(mrfdo_pkg::DEPTH_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	mrfdo_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_word   (req_word),
		.emit       (emit),
		.emit_ready (emit_ready),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata)
	);

	mrfdo_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit       (emit),
		.emit_ready (emit_ready),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_word   (rsp_word)
	);

endmodule

// ===== hw/rtl/mrfdo_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mrfdo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/mrfdo_out_reg.sv =====
// Output register holding one result word toward the receiver.
module mrfdo_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrfdo_pkg::emit_t     emit,
	output logic                 emit_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output mrfdo_pkg::rsp_word_t rsp_word
);

	logic                 valid_q;
	mrfdo_pkg::rsp_word_t word_q;

	assign emit_ready = !valid_q || !rsp_stall;
	assign rsp_valid  = valid_q;
	assign rsp_word   = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit_ready) begin
			valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ready && emit.valid)
			word_q <= emit.word;
	end

endmodule

// ===== hw/rtl/mrfdo_ctrl.sv =====
// Sequencer: store clearing, drop-oldest admission, word writes, commit and read-out.
module mrfdo_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  mrfdo_pkg::req_word_t req_word,
	output mrfdo_pkg::emit_t     emit,
	input  logic                 emit_ready,
	output mrfdo_pkg::ram_req_t  ram_req,
	input  logic [31:0]          ram_rdata
);

	mrfdo_pkg::state_t  state_q, state_d;
	mrfdo_pkg::idx_t    clr_q;
	mrfdo_pkg::idx_t    ri_q;
	mrfdo_pkg::idx_t    wi_q;
	mrfdo_pkg::idx_t    cur_q;
	mrfdo_pkg::idx_t    pos_q;
	mrfdo_pkg::lw_t     left_q;
	mrfdo_pkg::lw_t     need_q;
	mrfdo_pkg::lw_t     rleft_q;
	logic [7:0]         hdr_q;
	logic [7:0]         maxb_q;
	logic               last_q;
	logic               wopen_q;
	logic               wacc_q;
	logic [15:0]        held_q;
	logic [31:0]        drop_q;
	mrfdo_pkg::status_t st_q;

	mrfdo_pkg::sz_t     free_words;
	logic               fits;
	logic               blen_bad;
	mrfdo_pkg::lw_t     need_in;
	logic               too_deep;
	logic               cont_store;
	logic               rd_empty;
	logic               rd_big;
	logic               rd_ok;
	mrfdo_pkg::lw_t     rd_n;
	logic [15:0]        held_dec;
	logic [15:0]        held_inc;
	logic [31:0]        drop_inc;
	mrfdo_pkg::idx_t    next_wi;

	always_comb begin
		if (ri_q > wi_q)
			free_words = mrfdo_pkg::sz_t'(ri_q) - mrfdo_pkg::sz_t'(wi_q);
		else
			free_words = mrfdo_pkg::sz_t'(mrfdo_pkg::DEPTH_WORDS)
				- (mrfdo_pkg::sz_t'(wi_q) - mrfdo_pkg::sz_t'(ri_q));
	end

	assign fits     = free_words >= mrfdo_pkg::sz_t'(need_q) + mrfdo_pkg::sz_t'(1);
	assign need_in  = mrfdo_pkg::words_of(req_word.byte_length);
	assign blen_bad = (req_word.byte_length < 8'(mrfdo_pkg::HDR_MIN))
		|| ({1'b0, req_word.byte_length} > mrfdo_pkg::blen_t'(mrfdo_pkg::MAX_BYTES));
	assign too_deep = mrfdo_pkg::sz_t'(need_in) + mrfdo_pkg::sz_t'(1)
		> mrfdo_pkg::sz_t'(mrfdo_pkg::DEPTH_WORDS);
	assign cont_store = wacc_q && (left_q != '0);

	assign rd_empty = ram_rdata == 32'd0;
	assign rd_big   = ram_rdata > {24'd0, maxb_q};
	assign rd_ok    = !rd_empty && !rd_big;
	assign rd_n     = mrfdo_pkg::record_words(ram_rdata);
	assign held_dec = (held_q != 16'd0) ? held_q - 16'd1 : held_q;
	assign held_inc = (held_q != 16'hFFFF) ? held_q + 16'd1 : held_q;
	assign drop_inc = (drop_q != 32'hFFFF_FFFF) ? drop_q + 32'd1 : drop_q;
	assign next_wi  = mrfdo_pkg::wrap_add(wi_q, mrfdo_pkg::sz_t'(need_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mrfdo_pkg::S_CLEAR: begin
				if (clr_q == mrfdo_pkg::idx_t'(mrfdo_pkg::DEPTH_WORDS - 1))
					state_d = mrfdo_pkg::S_IDLE;
			end
			mrfdo_pkg::S_IDLE: begin
				if (req_valid) begin
					if (req_word.action == mrfdo_pkg::ACT_READ)
						state_d = mrfdo_pkg::S_RD_HDR;
					else if (!wopen_q)
						state_d = (blen_bad || too_deep) ? mrfdo_pkg::S_WR_FIN
							: mrfdo_pkg::S_DROP;
					else if (req_word.last && wacc_q)
						state_d = mrfdo_pkg::S_COMMIT_ZERO;
					else
						state_d = mrfdo_pkg::S_WR_EMIT;
				end
			end
			mrfdo_pkg::S_DROP: begin
				state_d = fits ? mrfdo_pkg::S_WR_FIN : mrfdo_pkg::S_DROP_CHK;
			end
			mrfdo_pkg::S_DROP_CHK: begin
				state_d = rd_empty ? mrfdo_pkg::S_WR_FIN : mrfdo_pkg::S_DROP;
			end
			mrfdo_pkg::S_WR_FIN: begin
				state_d = (last_q && wacc_q) ? mrfdo_pkg::S_COMMIT_ZERO
					: mrfdo_pkg::S_WR_EMIT;
			end
			mrfdo_pkg::S_COMMIT_ZERO: state_d = mrfdo_pkg::S_COMMIT_HDR;
			mrfdo_pkg::S_COMMIT_HDR:  state_d = mrfdo_pkg::S_WR_EMIT;
			mrfdo_pkg::S_WR_EMIT: begin
				if (emit_ready)
					state_d = mrfdo_pkg::S_IDLE;
			end
			mrfdo_pkg::S_RD_HDR: begin
				if (emit_ready)
					state_d = (rd_ok && rd_n > mrfdo_pkg::lw_t'(1)) ? mrfdo_pkg::S_RD_REQ
						: mrfdo_pkg::S_IDLE;
			end
			mrfdo_pkg::S_RD_REQ: state_d = mrfdo_pkg::S_RD_WORD;
			mrfdo_pkg::S_RD_WORD: begin
				if (emit_ready)
					state_d = (rleft_q == mrfdo_pkg::lw_t'(1)) ? mrfdo_pkg::S_IDLE
						: mrfdo_pkg::S_RD_REQ;
			end
			default: state_d = mrfdo_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall     = state_q != mrfdo_pkg::S_IDLE;
		ram_req       = '0;
		emit          = '0;
		emit.word.message_count = held_q;
		emit.word.lost_count    = drop_q;
		emit.word.status        = mrfdo_pkg::ST_OK;
		case (state_q)
			mrfdo_pkg::S_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_q;
			end
			mrfdo_pkg::S_IDLE: begin
				if (req_valid && req_word.action == mrfdo_pkg::ACT_READ) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = ri_q;
				end else if (req_valid && wopen_q && cont_store) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = cur_q;
					ram_req.wdata = req_word.data_word;
				end
			end
			mrfdo_pkg::S_DROP: begin
				if (!fits) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = ri_q;
				end
			end
			mrfdo_pkg::S_COMMIT_ZERO: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = next_wi;
			end
			mrfdo_pkg::S_COMMIT_HDR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = wi_q;
				ram_req.wdata = {24'd0, hdr_q};
			end
			mrfdo_pkg::S_WR_EMIT: begin
				emit.valid         = 1'b1;
				emit.word.last_out = 1'b1;
				emit.word.status   = st_q;
			end
			mrfdo_pkg::S_RD_HDR: begin
				emit.valid = 1'b1;
				if (rd_empty) begin
					emit.word.last_out = 1'b1;
					emit.word.status   = mrfdo_pkg::ST_EMPTY;
				end else if (rd_big) begin
					emit.word.word_out = ram_rdata;
					emit.word.last_out = 1'b1;
					emit.word.status   = mrfdo_pkg::ST_BIG;
				end else begin
					emit.word.word_out      = ram_rdata;
					emit.word.last_out      = rd_n == mrfdo_pkg::lw_t'(1);
					emit.word.message_count = held_dec;
				end
			end
			mrfdo_pkg::S_RD_REQ: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = pos_q;
			end
			mrfdo_pkg::S_RD_WORD: begin
				emit.valid         = 1'b1;
				emit.word.word_out = ram_rdata;
				emit.word.last_out = rleft_q == mrfdo_pkg::lw_t'(1);
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrfdo_pkg::S_CLEAR;
			clr_q   <= '0;
			ri_q    <= '0;
			wi_q    <= '0;
			cur_q   <= '0;
			pos_q   <= '0;
			left_q  <= '0;
			need_q  <= '0;
			rleft_q <= '0;
			hdr_q   <= '0;
			maxb_q  <= '0;
			last_q  <= 1'b0;
			wopen_q <= 1'b0;
			wacc_q  <= 1'b0;
			held_q  <= '0;
			drop_q  <= '0;
			st_q    <= mrfdo_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				mrfdo_pkg::S_CLEAR: begin
					clr_q <= clr_q + mrfdo_pkg::idx_t'(1);
				end
				mrfdo_pkg::S_IDLE: begin
					if (req_valid && req_word.action == mrfdo_pkg::ACT_READ) begin
						maxb_q <= req_word.max_bytes;
					end else if (req_valid && !wopen_q) begin
						wopen_q <= 1'b1;
						wacc_q  <= 1'b0;
						last_q  <= req_word.last;
						hdr_q   <= req_word.byte_length;
						need_q  <= need_in;
					end else if (req_valid) begin
						st_q <= wacc_q ? mrfdo_pkg::ST_OK : mrfdo_pkg::ST_REJECT;
						if (cont_store) begin
							cur_q  <= mrfdo_pkg::wrap_add(cur_q, mrfdo_pkg::sz_t'(1));
							left_q <= left_q - mrfdo_pkg::lw_t'(1);
						end
						if (req_word.last && !wacc_q) begin
							wopen_q <= 1'b0;
							left_q  <= '0;
						end
					end
				end
				mrfdo_pkg::S_DROP: begin
					if (fits) begin
						wacc_q <= 1'b1;
						left_q <= need_q - mrfdo_pkg::lw_t'(1);
						cur_q  <= mrfdo_pkg::wrap_add(wi_q, mrfdo_pkg::sz_t'(1));
					end
				end
				mrfdo_pkg::S_DROP_CHK: begin
					if (!rd_empty) begin
						ri_q   <= mrfdo_pkg::wrap_add(ri_q, mrfdo_pkg::sz_t'(rd_n));
						held_q <= held_dec;
						drop_q <= drop_inc;
					end
				end
				mrfdo_pkg::S_WR_FIN: begin
					st_q <= wacc_q ? mrfdo_pkg::ST_OK : mrfdo_pkg::ST_REJECT;
					if (last_q && !wacc_q) begin
						wopen_q <= 1'b0;
						left_q  <= '0;
					end
				end
				mrfdo_pkg::S_COMMIT_HDR: begin
					wi_q    <= next_wi;
					held_q  <= held_inc;
					wopen_q <= 1'b0;
					wacc_q  <= 1'b0;
					left_q  <= '0;
				end
				mrfdo_pkg::S_RD_HDR: begin
					if (emit_ready && rd_ok) begin
						ri_q    <= mrfdo_pkg::wrap_add(ri_q, mrfdo_pkg::sz_t'(rd_n));
						pos_q   <= mrfdo_pkg::wrap_add(ri_q, mrfdo_pkg::sz_t'(1));
						rleft_q <= rd_n - mrfdo_pkg::lw_t'(1);
						held_q  <= held_dec;
					end
				end
				mrfdo_pkg::S_RD_REQ: begin
					pos_q <= mrfdo_pkg::wrap_add(pos_q, mrfdo_pkg::sz_t'(1));
				end
				mrfdo_pkg::S_RD_WORD: begin
					if (emit_ready)
						rleft_q <= rleft_q - mrfdo_pkg::lw_t'(1);
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

endmodule

// ===== dv/ring_store_checker.sv =====
// Checker for the message ring store: predicts every response word and compares in order.
module ring_store_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  mrfdo_pkg::req_word_t req_word,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  mrfdo_pkg::rsp_word_t rsp_word,
	output int                   fail_count,
	output int                   pending,
	output int                   checked,
	output int                   drops
);
	import mrfdo_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic [31:0] mem [DEPTH_WORDS];
	idx_t        rd_ptr;
	idx_t        wr_ptr;
	idx_t        fill_ptr;
	logic [15:0] held;
	logic [31:0] lost;
	logic        in_msg;
	logic        msg_ok;
	int unsigned words_due;
	logic [7:0]  pend_len;
	rsp_word_t   expq [$];

	// record span in words, header included, clamped to the largest record
	function automatic int unsigned rec_span(input logic [31:0] hdr);
		logic [32:0] n;
		n = (33'(hdr) + 33'd3) >> 2;
		if (n > 33'(MAX_MSG_WORDS))
			return MAX_MSG_WORDS;
		return 32'(n);
	endfunction

	function automatic idx_t ring_step(input idx_t a, input int unsigned b);
		return idx_t'((int'(a) + b) % DEPTH_WORDS);
	endfunction

	function automatic int unsigned room();
		if (rd_ptr > wr_ptr)
			return int'(rd_ptr) - int'(wr_ptr);
		return DEPTH_WORDS - (int'(wr_ptr) - int'(rd_ptr));
	endfunction

	function automatic void push_rsp(input logic [31:0] w, input logic lst, input status_t st);
		rsp_word_t r;
		r.word_out      = w;
		r.last_out      = lst;
		r.status        = st;
		r.message_count = held;
		r.lost_count    = lost;
		expq.push_back(r);
	endfunction

	// first word: check the length, then drop oldest records until the new one plus end marker fits or none is left
	function automatic void open_msg(input logic [7:0] len);
		int unsigned need;
		in_msg = 1'b1;
		msg_ok = 1'b0;
		if (len < HDR_MIN || len > MAX_BYTES)
			return;
		need = rec_span(32'(len));
		if (need + 1 > DEPTH_WORDS)
			return;
		while (room() < need + 1 && mem[rd_ptr] != 32'd0) begin
			rd_ptr = ring_step(rd_ptr, rec_span(mem[rd_ptr]));
			if (held != 16'd0)
				held--;
			if (lost != 32'hFFFF_FFFF)
				lost++;
		end
		if (room() < need + 1)
			return;
		msg_ok    = 1'b1;
		pend_len  = len;
		words_due = need - 1;
		fill_ptr  = ring_step(wr_ptr, 1);
	endfunction

	function automatic void close_msg();
		idx_t nxt;
		nxt = ring_step(wr_ptr, rec_span(32'(pend_len)));
		mem[nxt]    = 32'd0;
		mem[wr_ptr] = 32'(pend_len);
		wr_ptr      = nxt;
		if (held != 16'hFFFF)
			held++;
	endfunction

	function automatic void predict(input req_word_t w);
		status_t     st;
		logic [31:0] hdr;
		int unsigned n;
		idx_t        pos;
		if (w.action == ACT_WRITE) begin
			if (!in_msg) begin
				open_msg(w.byte_length);
			end else if (msg_ok && words_due > 0) begin
				mem[fill_ptr] = w.data_word;
				fill_ptr      = ring_step(fill_ptr, 1);
				words_due--;
			end
			st = msg_ok ? ST_OK : ST_REJECT;
			if (w.last) begin
				if (msg_ok)
					close_msg();
				in_msg    = 1'b0;
				msg_ok    = 1'b0;
				words_due = 0;
			end
			push_rsp(32'd0, 1'b1, st);
		end else begin
			hdr = mem[rd_ptr];
			if (hdr == 32'd0) begin
				push_rsp(32'd0, 1'b1, ST_EMPTY);
			end else if (hdr > 32'(w.max_bytes)) begin
				push_rsp(hdr, 1'b1, ST_BIG);
			end else begin
				n      = rec_span(hdr);
				pos    = rd_ptr;
				rd_ptr = ring_step(rd_ptr, n);
				if (held != 16'd0)
					held--;
				for (int unsigned i = 0; i < n; i++) begin
					push_rsp(mem[pos], i + 1 == n, ST_OK);
					pos = ring_step(pos, 1);
				end
			end
		end
	endfunction

	function automatic void match(input rsp_word_t got);
		rsp_word_t e;
		if (expq.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("unexpected response: word %08h last %0d status %0d count %0d lost %0d",
					got.word_out, got.last_out, got.status, got.message_count,
					got.lost_count);
			return;
		end
		e = expq.pop_front();
		checked++;
		if (got.word_out !== e.word_out || got.last_out !== e.last_out ||
			got.status !== e.status || got.message_count !== e.message_count ||
			got.lost_count !== e.lost_count) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT) begin
				$display("response %0d mismatch", checked);
				$display("  expected word %08h last %0d status %0d count %0d lost %0d",
					e.word_out, e.last_out, e.status, e.message_count, e.lost_count);
				$display("  actual   word %08h last %0d status %0d count %0d lost %0d",
					got.word_out, got.last_out, got.status, got.message_count,
					got.lost_count);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH_WORDS; i++)
				mem[i] = 32'd0;
			rd_ptr     = '0;
			wr_ptr     = '0;
			fill_ptr   = '0;
			held       = '0;
			lost       = '0;
			in_msg     = 1'b0;
			msg_ok     = 1'b0;
			words_due  = 0;
			pend_len   = '0;
			expq.delete();
			fail_count = 0;
			pending    = 0;
			checked    = 0;
			drops      = 0;
		end else begin
			if (req_valid && !req_stall)
				predict(req_word);
			if (rsp_valid && !rsp_stall)
				match(rsp_word);
			pending = expq.size();
			drops   = int'(lost);
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives request words and response stalls into the ring store, gives the verdict.
module tb_top;
	import mrfdo_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASES         = 4;
	localparam int OPS_PER_PHASE  = 6;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req_word;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp_word;

	int fail_count;
	int pending;
	int checked;
	int drops;
	int words_sent;
	int msgs_sent;
	int reads_sent;
	int stall_left;
	int idle_cycles;
	bit quiet;

	message_ring_fifo_drop_oldest u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

	ring_store_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_word   (req_word),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_word   (rsp_word),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.drops      (drops)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly short gaps, a few long ones; none in quiet stretches
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (quiet || p < 60)
			return 0;
		if (p < 85)
			return $urandom_range(1, 2);
		if (p < 96)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_word_t mk_write(input logic [7:0] len, input logic lst);
		req_word_t w;
		w.action      = ACT_WRITE;
		w.data_word   = rnd_word();
		w.byte_length = len;
		w.last        = lst;
		w.max_bytes   = 8'($urandom);
		return w;
	endfunction

	task automatic send_word(input req_word_t w);
		int gap;
		gap = gap_len();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (req_stall);
		words_sent++;
	endtask

	task automatic read_req(input logic [7:0] limit);
		req_word_t w;
		w.action      = ACT_READ;
		w.data_word   = rnd_word();
		w.byte_length = 8'($urandom);
		w.last        = 1'($urandom);
		w.max_bytes   = limit;
		send_word(w);
		reads_sent++;
	endtask

	function automatic logic [7:0] pick_limit();
		int p;
		p = $urandom_range(0, 9);
		if (p < 6)
			return 8'(MAX_BYTES);
		if (p < 9)
			return 8'($urandom_range(0, MAX_BYTES));
		return 8'($urandom_range(0, 255));
	endfunction

	// header word carries len; later words carry random lengths, which are ignored
	task automatic write_msg(input logic [7:0] len, input int nwords, input bit mix_reads);
		for (int k = 0; k < nwords; k++) begin
			send_word(mk_write(k == 0 ? len : 8'($urandom), k == nwords - 1));
			if (mix_reads && k < nwords - 1 && $urandom_range(0, 29) == 0)
				read_req(pick_limit());
		end
		msgs_sent++;
	endtask

	task automatic random_op();
		int p;
		int len;
		int span;
		int nw;
		p = $urandom_range(0, 99);
		if (p < 25) begin
			read_req(pick_limit());
		end else if (p < 30) begin
			len = $urandom_range(0, 1) ? $urandom_range(0, HDR_MIN - 1)
				: $urandom_range(MAX_BYTES + 1, 255);
			write_msg(8'(len), $urandom_range(1, 3), 1'b1);
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2: len = HDR_MIN;
				3, 4:    len = MAX_BYTES;
				default: len = $urandom_range(HDR_MIN, 32);
			endcase
			span = (len + 3) / 4;
			nw   = span;
			if (p < 38) begin
				if (span > 1 && $urandom_range(0, 1))
					nw = $urandom_range(1, span - 1);
				else
					nw = span + $urandom_range(1, 3);
			end
			write_msg(8'(len), nw, 1'b1);
		end
	endtask

	initial begin
		rsp_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
				if ($urandom_range(0, 2) == 0)
					stall_left = gap_len();
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
			WATCHDOG_LIMIT, pending);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req_word   = '0;
		quiet      = 1'b0;
		words_sent = 0;
		msgs_sent  = 0;
		reads_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		read_req(8'(MAX_BYTES));
		write_msg(8'd0, 1, 1'b0);
		write_msg(8'd3, 2, 1'b0);
		write_msg(8'(MAX_BYTES + 1), 1, 1'b0);
		write_msg(8'd255, 1, 1'b0);
		write_msg(8'd4, 1, 1'b0);
		write_msg(8'd5, 2, 1'b0);
		read_req(8'd4);
		read_req(8'd4);
		read_req(8'(MAX_BYTES));
		// short record, then one with extra words
		write_msg(8'd12, 2, 1'b0);
		write_msg(8'd8, 4, 1'b0);
		// read served while a write is open
		send_word(mk_write(8'd6, 1'b0));
		read_req(8'd255);
		send_word(mk_write(8'd6, 1'b1));
		msgs_sent++;
		read_req(8'd0);
		read_req(8'(MAX_BYTES));
		read_req(8'(MAX_BYTES));
		read_req(8'(MAX_BYTES));

		for (int ph = 0; ph < PHASES; ph++) begin
			quiet = (ph == 1);
			repeat (OPS_PER_PHASE) random_op();
		end
		quiet = 1'b0;
		@(negedge clk);
		req_valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d request words, %0d messages written, %0d read requests",
			words_sent, msgs_sent, reads_sent);
		$display("run: %0d response words checked, %0d old messages dropped for room",
			checked, drops);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d failures, %0d responses never arrived", fail_count, pending);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
